/* sv/cfd_pkg.sv */
// shared types and constants of the cppm frame decoder
package cfd_pkg;

    typedef enum logic [2:0] {
        OP_EDGE        = 3'd0,
        OP_READ_CH     = 3'd1,
        OP_TEST_SYNC   = 3'd2,
        OP_READ_PERIOD = 3'd3,
        OP_SUSPEND     = 3'd4,
        OP_RESUME      = 3'd5
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] time_us;
        logic [3:0]  channel_number;
        logic [2:0]  client_index;
    } item_t;

    typedef struct packed {
        logic [15:0] pulse_us;
        logic [3:0]  channel_count;
        logic [15:0] period_us;
        logic        sync_seen;
    } result_t;

    localparam logic REG_SYNC_THRESHOLD = 1'b0;
    localparam logic REG_NEUTRAL_WIDTH  = 1'b1;

    localparam logic [15:0] RESET_SYNC    = 16'd3000;
    localparam logic [15:0] RESET_NEUTRAL = 16'd1500;
    localparam logic [7:0]  ALL_CLIENTS   = 8'hFF;

endpackage

/* sv/cfd_in_stage.sv */
// input register stage of the cppm frame decoder
module cfd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cfd_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output cfd_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    cfd_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/cfd_engine.sv */
// decoder state, configuration registers and per-beat result logic
module cfd_engine #(
    parameter int MAX_CHANNELS = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_wr_data,
    input  logic             fire,
    input  cfd_pkg::item_t   item,
    output cfd_pkg::result_t result
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 2);
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] IDLE_INDEX = CNT_W'(MAX_CHANNELS + 1);
    localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(MAX_CHANNELS);

    logic [15:0]      thr_reg;
    logic [15:0]      neutral_reg;
    logic [15:0]      widths_reg [MAX_CHANNELS];
    logic [CNT_W-1:0] index_reg;
    logic [CNT_W-1:0] index_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       flags_reg;
    logic [7:0]       flags_next;
    logic [15:0]      prev_reg;
    logic [15:0]      prev_next;
    logic [15:0]      start_reg;
    logic [15:0]      start_next;
    logic [15:0]      period_reg;
    logic [15:0]      period_next;
    logic             phase_reg;
    logic             phase_next;
    logic             enabled_reg;
    logic             enabled_next;

    logic [15:0]      gap;
    logic             is_sync;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [3:0]       rd_num;
    logic [AW-1:0]    rd_addr;
    logic             rd_hit;

    assign gap     = item.time_us - prev_reg;
    assign is_sync = gap >= thr_reg;
    assign wr_addr = index_reg[AW-1:0];
    assign rd_num  = item.channel_number - 4'd1;
    assign rd_addr = rd_num[AW-1:0];
    assign rd_hit  = (item.channel_number != 4'd0)
                  && (item.channel_number <= 4'(count_reg))
                  && ({1'b0, item.channel_number} <= 5'(MAX_CHANNELS));

    always_comb begin
        index_next   = index_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        prev_next    = prev_reg;
        start_next   = start_reg;
        period_next  = period_reg;
        phase_next   = phase_reg;
        enabled_next = enabled_reg;
        wr_en        = 1'b0;
        result.pulse_us  = 16'd0;
        result.sync_seen = 1'b0;
        unique case (item.op)
            cfd_pkg::OP_EDGE: begin
                if (enabled_reg) begin
                    prev_next = item.time_us;
                    if (is_sync) begin
                        count_next = (index_reg > LAST_INDEX) ? '0 : index_reg;
                        index_next = '0;
                        flags_next = cfd_pkg::ALL_CLIENTS;
                        phase_next = ~phase_reg;
                        if (!phase_reg) begin
                            start_next = item.time_us;
                        end else begin
                            period_next = item.time_us - start_reg;
                        end
                    end else if (index_reg < LAST_INDEX) begin
                        wr_en      = 1'b1;
                        index_next = index_reg + CNT_W'(1);
                    end
                end
            end
            cfd_pkg::OP_READ_CH: begin
                result.pulse_us = rd_hit ? widths_reg[rd_addr] : neutral_reg;
            end
            cfd_pkg::OP_TEST_SYNC: begin
                result.sync_seen = flags_reg[item.client_index];
                flags_next[item.client_index] = 1'b0;
            end
            cfd_pkg::OP_SUSPEND: begin
                enabled_next = 1'b0;
                index_next   = IDLE_INDEX;
            end
            cfd_pkg::OP_RESUME: begin
                prev_next    = item.time_us;
                enabled_next = 1'b1;
            end
            default: begin
            end
        endcase
        result.channel_count = 4'(count_next);
        result.period_us     = period_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= cfd_pkg::RESET_SYNC;
            neutral_reg <= cfd_pkg::RESET_NEUTRAL;
            index_reg   <= IDLE_INDEX;
            count_reg   <= '0;
            flags_reg   <= '0;
            prev_reg    <= '0;
            start_reg   <= '0;
            period_reg  <= '0;
            phase_reg   <= 1'b0;
            enabled_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cfd_pkg::REG_SYNC_THRESHOLD: thr_reg     <= cfg_wr_data;
                    cfd_pkg::REG_NEUTRAL_WIDTH:  neutral_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                index_reg   <= index_next;
                count_reg   <= count_next;
                flags_reg   <= flags_next;
                prev_reg    <= prev_next;
                start_reg   <= start_next;
                period_reg  <= period_next;
                phase_reg   <= phase_next;
                enabled_reg <= enabled_next;
            end
        end
    end

    // channel widths: entries below the detected count are always written before a read
    always_ff @(posedge aclk) begin
        if (fire && wr_en) begin
            widths_reg[wr_addr] <= gap;
        end
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= IDLE_INDEX)
        else $error("channel index beyond idle value");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_INDEX)
        else $error("detected count beyond channel limit");

    a_sync_sets_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == cfd_pkg::OP_EDGE && enabled_reg && is_sync
        |=> flags_reg == cfd_pkg::ALL_CLIENTS && index_reg == '0)
        else $error("sync gap did not restart frame");

    a_suspend_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == cfd_pkg::OP_SUSPEND
        |=> !enabled_reg && index_reg == IDLE_INDEX)
        else $error("suspend did not idle collection");

    a_disabled_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == cfd_pkg::OP_EDGE && !enabled_reg
        |=> $stable(prev_reg) && $stable(index_reg) && $stable(count_reg))
        else $error("edge changed state while suspended");
`endif

endmodule

/* sv/cfd_out_stage.sv */
// result register stage of the cppm frame decoder
module cfd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  cfd_pkg::result_t result,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output cfd_pkg::result_t m_result
);

    logic             valid_reg;
    cfd_pkg::result_t result_reg;

    assign space = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (space) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

/* sv/cppm_frame_decoder_unit.sv */
// top level of the cppm frame decoder
// Decodes a CPPM stream from rising-edge timestamps and serves channel widths,
// per-client sync flags and the frame period. Every input beat (edge, read
// channel, test-and-clear sync, read period, suspend, resume) yields exactly
// one result beat. A beat is registered at the input, resolved combinationally
// against the decoder state by a 16-bit subtract and compare, and registered
// at the output; m_valid rises once the beat reaches the output register, and
// one beat is accepted every cycle while m_ready stays high. Configuration
// writes (index 0 sync threshold, index 1 neutral width) take effect at once.
module cppm_frame_decoder_unit #(
    parameter int MAX_CHANNELS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [15:0] s_time_us,
    input  logic [3:0]  s_channel_number,
    input  logic [2:0]  s_client_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pulse_us,
    output logic [3:0]  m_channel_count,
    output logic [15:0] m_period_us,
    output logic        m_sync_seen
);

    cfd_pkg::item_t   s_item;
    cfd_pkg::item_t   item;
    cfd_pkg::result_t result;
    cfd_pkg::result_t m_result;
    logic             item_valid;
    logic             space;
    logic             advance;

    assign s_item.op             = cfd_pkg::op_t'(s_op);
    assign s_item.time_us        = s_time_us;
    assign s_item.channel_number = s_channel_number;
    assign s_item.client_index   = s_client_index;

    assign advance = item_valid && space;

    cfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cfd_engine #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .item        (item),
        .result      (result)
    );

    cfd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_pulse_us      = m_result.pulse_us;
    assign m_channel_count = m_result.channel_count;
    assign m_period_us     = m_result.period_us;
    assign m_sync_seen     = m_result.sync_seen;

endmodule
